// ===== rtl/slpc_pkg.sv =====
package slpc_pkg;

  // default sizing
  localparam int MAX_SHAPES_DEF = 16;
  localparam int MAX_DIM_DEF    = 64;

  // field widths
  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int POS_W    = 6;
  localparam int SIZE_W   = 7;
  localparam int BRUSH_W  = 8;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int DIM_W    = 7;

  // config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register indexes (selected by paddr[2])
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [DIM_W-1:0]   CANVAS_RESET = 7'd10;
  localparam logic [BRUSH_W-1:0] BLANK_PIXEL  = 8'd46;

  // operations
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // shape kinds
  localparam logic [KIND_W-1:0] KIND_RECT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUT       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

  // one display list entry
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [BRUSH_W-1:0] brush;
  } shape_t;

  // controller -> datapath
  typedef struct packed {
    logic idle;
    logic start;
    logic shift_rd;
    logic shift_wr;
    logic del_done;
    logic scan_step;
    logic load_out;
  } slpc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic            in_fire;
    logic [OP_W-1:0] op;
    logic            del_ok;
    logic            pix_ok;
    logic            shift_more;
    logic            scan_done;
    logic            out_free;
  } slpc_stat_t;

endpackage

// ===== rtl/slpc_ifs.sv =====
interface slpc_item_if;
  import slpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [KIND_W-1:0]   shape_kind;
  logic [POS_W-1:0]    center_col;
  logic [POS_W-1:0]    center_row;
  logic [SIZE_W-1:0]   shape_width;
  logic [SIZE_W-1:0]   shape_height;
  logic [BRUSH_W-1:0]  brush_char;
  logic [IDX_W-1:0]    entry_index;
  logic [POS_W-1:0]    pixel_row;
  logic [POS_W-1:0]    pixel_col;

  modport source (
    output valid, op, shape_kind, center_col, center_row, shape_width,
           shape_height, brush_char, entry_index, pixel_row, pixel_col,
    input  ready
  );
  modport sink (
    input  valid, op, shape_kind, center_col, center_row, shape_width,
           shape_height, brush_char, entry_index, pixel_row, pixel_col,
    output ready
  );
endinterface

interface slpc_result_if;
  import slpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  shape_count;
  logic [BRUSH_W-1:0]  pixel_value;

  modport source (output valid, status, shape_count, pixel_value, input ready);
  modport sink   (input valid, status, shape_count, pixel_value, output ready);
endinterface

// ===== rtl/slpc_regs.sv =====
module slpc_regs #(
  parameter int MAX_DIM = slpc_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [slpc_pkg::PDATA_W-1:0]  pwdata,
  output logic [slpc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [slpc_pkg::DIM_W-1:0]    canvas_rows,
  output logic [slpc_pkg::DIM_W-1:0]    canvas_cols
);
  import slpc_pkg::*;

  logic             wr_en;
  logic [DIM_W-1:0] wr_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // values above the largest canvas are held at it
  always_comb begin
    wr_val = pwdata[DIM_W-1:0];
    if (int'(pwdata[DIM_W-1:0]) > MAX_DIM) begin
      wr_val = DIM_W'(MAX_DIM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_rows <= CANVAS_RESET;
      canvas_cols <= CANVAS_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_ROWS) begin
        canvas_rows <= wr_val;
      end else begin
        canvas_cols <= wr_val;
      end
    end
  end

  // read back
  assign prdata = (paddr[2] == REG_COLS) ? PDATA_W'(canvas_cols) : PDATA_W'(canvas_rows);

endmodule

// ===== rtl/slpc_ctrl.sv =====
module slpc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  slpc_pkg::slpc_stat_t stat,
  output slpc_pkg::slpc_cmd_t  cmd
);
  import slpc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_START    = 6'b000010,
    S_SHIFT_RD = 6'b000100,
    S_SHIFT_WR = 6'b001000,
    S_SCAN     = 6'b010000,
    S_RESULT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (stat.in_fire) state_next = S_START;
      end
      S_START: begin
        cmd.start = 1'b1;
        if (stat.op == OP_DEL && stat.del_ok) begin
          state_next = S_SHIFT_RD;
        end else if (stat.op == OP_QUERY && stat.pix_ok) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_RESULT;
        end
      end
      // close the gap one entry per read/write pair
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHIFT_WR;
        end else begin
          cmd.del_done = 1'b1;
          state_next   = S_RESULT;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_RESULT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/slpc_dp.sv =====
module slpc_dp #(
  parameter int MAX_SHAPES = slpc_pkg::MAX_SHAPES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  slpc_item_if.sink                  items,
  slpc_result_if.source              results,
  input  logic [slpc_pkg::DIM_W-1:0] canvas_rows,
  input  logic [slpc_pkg::DIM_W-1:0] canvas_cols,
  input  slpc_pkg::slpc_cmd_t        cmd,
  output slpc_pkg::slpc_stat_t       stat
);
  import slpc_pkg::*;

  localparam int CW = $clog2(MAX_SHAPES + 1);
  localparam int AW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;

  // size and bounds check of a new shape against the canvas
  function automatic logic [STATUS_W-1:0] check_shape(
    shape_t s, logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
    logic signed [9:0] x, y, w, hw, hh, rr, cc;
    logic signed [9:0] lo_r, hi_r, lo_c, hi_c;
    logic              bad;
    x    = 10'(s.x);
    y    = 10'(s.y);
    w    = 10'(s.w);
    hw   = 10'(s.w >> 1);
    hh   = 10'(s.h >> 1);
    rr   = 10'(rows);
    cc   = 10'(cols);
    bad  = 1'b0;
    lo_r = y;
    hi_r = y;
    lo_c = x;
    hi_c = x;
    unique case (s.kind)
      KIND_RECT: begin
        bad  = !s.w[0] || !s.h[0];
        lo_r = y - hh;
        hi_r = y + hh;
        lo_c = x - hw;
        hi_c = x + hw;
      end
      KIND_UP, KIND_DOWN: begin
        bad = (s.w == '0);
        if (s.kind == KIND_UP) begin
          lo_r = y;
          hi_r = y + w - 10'sd1;
        end else begin
          lo_r = y - w + 10'sd1;
          hi_r = y;
        end
        lo_c = x - w + 10'sd1;
        hi_c = x + w - 10'sd1;
      end
      default: bad = 1'b1;
    endcase
    priority if (bad) begin
      return ST_BAD_SIZE;
    end else if (lo_r < 0 || hi_r >= rr || lo_c < 0 || hi_c >= cc) begin
      return ST_OUT;
    end else begin
      return ST_OK;
    end
  endfunction

  // pixel coverage by one stored shape
  function automatic logic covers(shape_t s, logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    logic signed [8:0] dr, dc, adr, adc, d, wm1, hw, hh;
    dr  = 9'(r) - 9'(s.y);
    dc  = 9'(c) - 9'(s.x);
    adr = (dr < 0) ? -dr : dr;
    adc = (dc < 0) ? -dc : dc;
    wm1 = 9'(s.w) - 9'sd1;
    hw  = 9'(s.w >> 1);
    hh  = 9'(s.h >> 1);
    unique case (s.kind)
      KIND_RECT: return (adr <= hh) && (adc <= hw);
      KIND_UP: begin
        d = dr;
        return (d >= 0) && (d <= wm1) && (adc <= d);
      end
      KIND_DOWN: begin
        d = -dr;
        return (d >= 0) && (d <= wm1) && (adc <= d);
      end
      default: return 1'b0;
    endcase
  endfunction

  // latched item
  logic [OP_W-1:0]  op_q;
  shape_t           shp_q;
  logic [IDX_W-1:0] idx_q;
  logic [POS_W-1:0] prow_q;
  logic [POS_W-1:0] pcol_q;

  // list state
  shape_t          mem [MAX_SHAPES];
  shape_t          rdata;
  logic [CW-1:0]   count;
  logic [CW-1:0]   ptr;
  logic            ev_valid;
  logic [STATUS_W-1:0] status_q;
  logic [BRUSH_W-1:0]  pixel_q;

  logic                in_fire;
  logic [STATUS_W-1:0] chk_st;
  logic [STATUS_W-1:0] add_st;
  logic [STATUS_W-1:0] start_st;
  logic                add_wr;
  logic                full;
  logic                we;
  logic [AW-1:0]       waddr;
  shape_t              wdata;
  logic [CW-1:0]       raddr;
  logic [CW:0]         ptr_inc;
  logic                out_valid;

  // no word is taken while reset is held
  assign items.ready = cmd.idle && !rst;
  assign in_fire     = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q        <= items.op;
      shp_q.kind  <= items.shape_kind;
      shp_q.x     <= items.center_col;
      shp_q.y     <= items.center_row;
      shp_q.w     <= items.shape_width;
      shp_q.h     <= items.shape_height;
      shp_q.brush <= items.brush_char;
      idx_q       <= items.entry_index;
      prow_q      <= items.pixel_row;
      pcol_q      <= items.pixel_col;
    end
  end

  // status of the operation
  assign chk_st  = check_shape(shp_q, canvas_rows, canvas_cols);
  assign full    = (count == CW'(MAX_SHAPES));
  assign add_st  = (chk_st != ST_OK) ? chk_st : (full ? ST_FULL : ST_OK);
  assign add_wr  = cmd.start && (op_q == OP_ADD) && (add_st == ST_OK);
  assign ptr_inc = (CW + 1)'(ptr) + 1'b1;

  assign stat.in_fire    = in_fire;
  assign stat.op         = op_q;
  assign stat.del_ok     = IW'(idx_q) < IW'(count);
  assign stat.pix_ok     = (DIM_W'(prow_q) < canvas_rows) && (DIM_W'(pcol_q) < canvas_cols);
  assign stat.shift_more = ptr_inc < (CW + 1)'(count);
  assign stat.scan_done  = (ptr >= count) && !ev_valid;
  assign stat.out_free   = !out_valid || results.ready;

  always_comb begin
    unique case (op_q)
      OP_ADD:   start_st = add_st;
      OP_DEL:   start_st = stat.del_ok ? ST_OK : ST_BAD_INDEX;
      OP_QUERY: start_st = stat.pix_ok ? ST_OK : ST_OUT;
      default:  start_st = ST_BAD_SIZE;
    endcase
  end

  // shape memory: one write port, one registered read port
  assign we    = add_wr || cmd.shift_wr;
  assign waddr = cmd.shift_wr ? ptr[AW-1:0] : count[AW-1:0];
  assign wdata = cmd.shift_wr ? rdata : shp_q;
  assign raddr = cmd.shift_rd ? ptr_inc[CW-1:0] : ptr;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr[AW-1:0]];
  end

  // list count and scan valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ev_valid <= 1'b0;
    end else begin
      if (add_wr) begin
        count <= count + 1'b1;
      end else if (cmd.del_done) begin
        count <= count - 1'b1;
      end
      if (cmd.start) begin
        ev_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        ev_valid <= (ptr < count);
      end
    end
  end

  // pointer, status and pixel answer
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr      <= (op_q == OP_DEL) ? CW'(idx_q) : '0;
      status_q <= start_st;
      pixel_q  <= BLANK_PIXEL;
    end else if (cmd.shift_wr) begin
      ptr <= ptr + 1'b1;
    end else if (cmd.scan_step) begin
      if (ptr < count) ptr <= ptr + 1'b1;
      // later entries lie on top
      if (ev_valid && covers(rdata, prow_q, pcol_q)) pixel_q <= rdata.brush;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      results.status      <= status_q;
      results.shape_count <= COUNT_W'(count);
      results.pixel_value <= pixel_q;
    end
  end

  assign results.valid = out_valid;

endmodule

// ===== rtl/shape_list_pixel_compositor.sv =====
// Display list of rectangles and triangles with pixel queries, one word at a time.
// Add, rejected delete, off-canvas query and unknown op go straight to the result; a delete
// first shifts each later entry down by one, and a query scans the list, one entry per cycle.
// The next word is accepted the cycle after the result enters the output register;
// a result still waiting in that register holds the block.
// Synchronous reset empties the list and sets both canvas sizes to 10.
module shape_list_pixel_compositor #(
  parameter int MAX_SHAPES = slpc_pkg::MAX_SHAPES_DEF,
  parameter int MAX_DIM    = slpc_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  slpc_item_if.sink                    items,
  slpc_result_if.source                results,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slpc_pkg::PADDR_W-1:0] paddr,
  input  logic [slpc_pkg::PDATA_W-1:0] pwdata,
  output logic [slpc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import slpc_pkg::*;

  logic [DIM_W-1:0] canvas_rows;
  logic [DIM_W-1:0] canvas_cols;
  slpc_cmd_t        cmd;
  slpc_stat_t       stat;

  slpc_regs #(.MAX_DIM(MAX_DIM)) u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .canvas_rows (canvas_rows),
    .canvas_cols (canvas_cols)
  );

  slpc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  slpc_dp #(.MAX_SHAPES(MAX_SHAPES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .results     (results),
    .canvas_rows (canvas_rows),
    .canvas_cols (canvas_cols),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// ===== verif/shape_list_pixel_compositor_tb.sv =====
`timescale 1ns / 1ps

module shape_list_pixel_compositor_tb;
  import slpc_pkg::*;

  localparam int MAX_SHAPES  = MAX_SHAPES_DEF;
  localparam int MAX_DIM     = MAX_DIM_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 30;
  localparam int REPORT_CAP  = 200;

  // codes the block treats as unknown
  localparam logic [OP_W-1:0]   OP_NONE   = 2'd3;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // one input word
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   center_col;
    logic [POS_W-1:0]   center_row;
    logic [SIZE_W-1:0]  shape_width;
    logic [SIZE_W-1:0]  shape_height;
    logic [BRUSH_W-1:0] brush;
    logic [IDX_W-1:0]   entry_index;
    logic [POS_W-1:0]   pixel_row;
    logic [POS_W-1:0]   pixel_col;
  } req_t;

  // one result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [BRUSH_W-1:0]  pixel;
  } answer_t;

  // mirror of the display list; predicts the answer to each accepted word
  class display_list_tracker;
    shape_t      shapes[MAX_SHAPES];
    int unsigned used;
    int          rows;
    int          cols;
    answer_t     pending_answers[$];
    int          errors;

    function new();
      used   = 0;
      rows   = int'(CANVAS_RESET);
      cols   = int'(CANVAS_RESET);
      errors = 0;
    endfunction

    function void set_dim(logic sel, int unsigned value);
      int d;
      d = int'(value & 32'h7f);
      if (d > MAX_DIM) d = MAX_DIM;
      if (sel == REG_ROWS) rows = d;
      else cols = d;
    endfunction

    function int mag(int a);
      return (a < 0) ? -a : a;
    endfunction

    // size checks first, then canvas bounds
    function logic [STATUS_W-1:0] fit_status(req_t w);
      int x, y, sw, sh, lo_r, hi_r, lo_c, hi_c;
      x  = int'(w.center_col);
      y  = int'(w.center_row);
      sw = int'(w.shape_width);
      sh = int'(w.shape_height);
      case (w.kind)
        KIND_RECT: begin
          if (sw % 2 == 0 || sh % 2 == 0) return ST_BAD_SIZE;
          lo_r = y - sh / 2;
          hi_r = y + sh / 2;
          lo_c = x - sw / 2;
          hi_c = x + sw / 2;
        end
        KIND_UP, KIND_DOWN: begin
          if (sw == 0) return ST_BAD_SIZE;
          if (w.kind == KIND_UP) begin
            lo_r = y;
            hi_r = y + sw - 1;
          end else begin
            lo_r = y - sw + 1;
            hi_r = y;
          end
          lo_c = x - sw + 1;
          hi_c = x + sw - 1;
        end
        default: return ST_BAD_SIZE;
      endcase
      if (lo_r < 0 || hi_r >= rows || lo_c < 0 || hi_c >= cols) return ST_OUT;
      return ST_OK;
    endfunction

    function bit covers(shape_t s, int r, int c);
      int sx, sy, sw, sh, d;
      sx = int'(s.x);
      sy = int'(s.y);
      sw = int'(s.w);
      sh = int'(s.h);
      case (s.kind)
        KIND_RECT: return mag(r - sy) <= sh / 2 && mag(c - sx) <= sw / 2;
        KIND_UP:   d = r - sy;
        KIND_DOWN: d = sy - r;
        default:   return 1'b0;
      endcase
      return d >= 0 && d <= sw - 1 && mag(c - sx) <= d;
    endfunction

    // apply one accepted word and queue its answer
    function void take_word(req_t w);
      answer_t a;
      shape_t  s;
      int      r, c;
      a.status = ST_OK;
      a.pixel  = BLANK_PIXEL;
      case (w.op)
        OP_ADD: begin
          a.status = fit_status(w);
          if (a.status == ST_OK) begin
            if (used >= MAX_SHAPES) begin
              a.status = ST_FULL;
            end else begin
              s.kind  = w.kind;
              s.x     = w.center_col;
              s.y     = w.center_row;
              s.w     = w.shape_width;
              s.h     = w.shape_height;
              s.brush = w.brush;
              shapes[used] = s;
              used++;
            end
          end
        end
        OP_DEL: begin
          if (w.entry_index >= used) begin
            a.status = ST_BAD_INDEX;
          end else begin
            for (int i = int'(w.entry_index); i + 1 < int'(used); i++)
              shapes[i] = shapes[i + 1];
            used--;
          end
        end
        OP_QUERY: begin
          r = int'(w.pixel_row);
          c = int'(w.pixel_col);
          if (r >= rows || c >= cols) begin
            a.status = ST_OUT;
          end else begin
            // last listed covering shape wins
            for (int i = 0; i < int'(used); i++)
              if (covers(shapes[i], r, c)) a.pixel = shapes[i].brush;
          end
        end
        default: a.status = ST_BAD_SIZE;
      endcase
      a.count = COUNT_W'(used);
      pending_answers = {pending_answers, a};
    endfunction

    function void note_error();
      errors++;
      if (errors == REPORT_CAP) $display("%0t: further mismatches not shown", $time);
    endfunction

    function void check_answer(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                               logic [BRUSH_W-1:0] pixel);
      answer_t e;
      if (pending_answers.size() == 0) begin
        if (errors < REPORT_CAP)
          $display("%0t: result with nothing expected: status=%0d count=%0d pixel=%0d",
                   $time, status, count, pixel);
        note_error();
        return;
      end
      e = pending_answers[0];
      pending_answers.delete(0);
      if (status !== e.status) begin
        if (errors < REPORT_CAP)
          $display("%0t: status mismatch: expected %0d, got %0d", $time, e.status, status);
        note_error();
      end
      if (count !== e.count) begin
        if (errors < REPORT_CAP)
          $display("%0t: shape_count mismatch: expected %0d, got %0d", $time, e.count, count);
        note_error();
      end
      if (pixel !== e.pixel) begin
        if (errors < REPORT_CAP)
          $display("%0t: pixel_value mismatch: expected %0d, got %0d", $time, e.pixel, pixel);
        note_error();
      end
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  slpc_item_if   items_if();
  slpc_result_if results_if();

  display_list_tracker tracker = new();

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_reqs    = 0;

  shape_list_pixel_compositor u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    int seen;
    hold_left = 0;
    seen = 0;
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (results_if.valid && results_if.ready)
        tracker.check_answer(results_if.status, results_if.shape_count, results_if.pixel_value);
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        results_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // word with every field random, unknown codes included
  function automatic req_t noise_word();
    req_t w;
    w.op           = OP_W'($urandom_range(3));
    w.kind         = KIND_W'($urandom_range(3));
    w.center_col   = POS_W'($urandom_range(63));
    w.center_row   = POS_W'($urandom_range(63));
    w.shape_width  = SIZE_W'($urandom_range(127));
    w.shape_height = SIZE_W'($urandom_range(127));
    w.brush        = BRUSH_W'($urandom_range(255));
    w.entry_index  = IDX_W'($urandom_range(15));
    w.pixel_row    = POS_W'($urandom_range(63));
    w.pixel_col    = POS_W'($urandom_range(63));
    return w;
  endfunction

  function automatic req_t make_add(logic [KIND_W-1:0] kind, int x, int y, int sw, int sh,
                                    logic [BRUSH_W-1:0] brush);
    req_t w;
    w = noise_word();
    w.op           = OP_ADD;
    w.kind         = kind;
    w.center_col   = POS_W'(x);
    w.center_row   = POS_W'(y);
    w.shape_width  = SIZE_W'(sw);
    w.shape_height = SIZE_W'(sh);
    w.brush        = brush;
    return w;
  endfunction

  function automatic req_t make_query(int r, int c);
    req_t w;
    w = noise_word();
    w.op        = OP_QUERY;
    w.pixel_row = POS_W'(r);
    w.pixel_col = POS_W'(c);
    return w;
  endfunction

  function automatic req_t make_del(int idx);
    req_t w;
    w = noise_word();
    w.op          = OP_DEL;
    w.entry_index = IDX_W'(idx);
    return w;
  endfunction

  // a shape that fits the current canvas
  function automatic req_t fitted_add();
    req_t w;
    int   hw, hh, t, tmax;
    w = noise_word();
    w.op   = OP_ADD;
    w.kind = KIND_W'($urandom_range(2));
    if (w.kind == KIND_RECT) begin
      hw = $urandom_range((tracker.cols - 1) / 2);
      hh = $urandom_range((tracker.rows - 1) / 2);
      w.shape_width  = SIZE_W'(2 * hw + 1);
      w.shape_height = SIZE_W'(2 * hh + 1);
      w.center_col   = POS_W'($urandom_range(tracker.cols - 1 - hw, hw));
      w.center_row   = POS_W'($urandom_range(tracker.rows - 1 - hh, hh));
    end else begin
      tmax = (tracker.cols + 1) / 2;
      if (tracker.rows < tmax) tmax = tracker.rows;
      t = $urandom_range(tmax, 1);
      w.shape_width = SIZE_W'(t);
      w.center_col  = POS_W'($urandom_range(tracker.cols - t, t - 1));
      if (w.kind == KIND_UP)
        w.center_row = POS_W'($urandom_range(tracker.rows - t, 0));
      else
        w.center_row = POS_W'($urandom_range(tracker.rows - 1, t - 1));
    end
    return w;
  endfunction

  // mostly well-formed traffic, some near misses and noise
  function automatic req_t pick_word();
    req_t w;
    int   p;
    p = $urandom_range(99);
    if (p < 33) begin
      w = fitted_add();
    end else if (p < 40) begin
      // shape nudged by one, often just off the canvas
      w = fitted_add();
      if ($urandom_range(1)) w.center_col = w.center_col + POS_W'(1);
      else w.center_row = w.center_row - POS_W'(1);
    end else if (p < 58 && tracker.used > 0) begin
      w = make_del($urandom_range(tracker.used - 1));
    end else if (p < 88) begin
      w = make_query($urandom_range(tracker.rows - 1), $urandom_range(tracker.cols - 1));
    end else begin
      w = noise_word();
    end
    return w;
  endfunction

  // offer one word, return at the edge that takes it; valid stays up
  task automatic send_word(input req_t w);
    if ($urandom_range(99) < src_idle_pct) begin
      items_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    items_if.valid        <= 1'b1;
    items_if.op           <= w.op;
    items_if.shape_kind   <= w.kind;
    items_if.center_col   <= w.center_col;
    items_if.center_row   <= w.center_row;
    items_if.shape_width  <= w.shape_width;
    items_if.shape_height <= w.shape_height;
    items_if.brush_char   <= w.brush;
    items_if.entry_index  <= w.entry_index;
    items_if.pixel_row    <= w.pixel_row;
    items_if.pixel_col    <= w.pixel_col;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    tracker.take_word(w);
  endtask

  // stop sending and wait for every outstanding answer
  task automatic drain();
    items_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_dim(sel, value);
    @(posedge clk);
  endtask

  task automatic run_random(input int n, input bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_reqs <= hold_reqs + 1;
      send_word(pick_word());
    end
  endtask

  task automatic run_directed();
    req_t w;
    send_word(make_query(0, 0));
    w = noise_word();
    w.op = OP_NONE;
    send_word(w);
    // even width and zero height rectangle
    send_word(make_add(KIND_RECT, 5, 5, 4, 0, 8'h65));
    send_word(make_add(KIND_UP, 5, 5, 0, 1, 8'h7a));
    send_word(make_add(KIND_NONE, 5, 5, 1, 1, 8'h3f));
    // one column past the left edge
    send_word(make_add(KIND_RECT, 0, 5, 3, 3, 8'h4c));
    send_word(make_add(KIND_RECT, 63, 63, 127, 127, 8'hff));
    send_word(make_del(15));
    send_word(make_add(KIND_RECT, 5, 5, 9, 9, 8'hff));
    send_word(make_add(KIND_UP, 5, 0, 5, 1, 8'h00));
    send_word(make_add(KIND_DOWN, 4, 9, 5, 1, 8'h44));
    // fill the list; the last add hits a full table
    repeat (14) send_word(fitted_add());
    send_word(make_query(5, 5));
    send_word(make_query(0, 5));
    send_word(make_query(63, 63));
    send_word(make_del(15));
    send_word(make_del(15));
    send_word(make_del(0));
  endtask

  initial begin
    items_if.valid        = 1'b0;
    items_if.op           = OP_ADD;
    items_if.shape_kind   = KIND_RECT;
    items_if.center_col   = '0;
    items_if.center_row   = '0;
    items_if.shape_width  = '0;
    items_if.shape_height = '0;
    items_if.brush_char   = '0;
    items_if.entry_index  = '0;
    items_if.pixel_row    = '0;
    items_if.pixel_col    = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default 10x10 canvas, slow receiver
    src_idle_pct = 18;
    snk_idle_pct = 57;
    run_directed();
    drain();
    run_random(250, 1'b1);
    drain();

    // largest canvas, the column size written above range
    write_reg(REG_ROWS, 64);
    write_reg(REG_COLS, 127);
    src_idle_pct = 57;
    snk_idle_pct = 18;
    run_random(230, 1'b0);
    drain();

    // smallest canvas; stored shapes stay in the list
    write_reg(REG_ROWS, 1);
    write_reg(REG_COLS, 1);
    run_random(40, 1'b0);
    drain();

    write_reg(REG_ROWS, $urandom_range(64, 1));
    write_reg(REG_COLS, $urandom_range(64, 1));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(260, 1'b1);
    drain();

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
